// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the steering core. Every check is sampled on aclk
// and switched off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must never hold.
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("assertion failed: condition must never hold");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_NEVER(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/vsu_pkg.sv =====
// ----------------------------------------------------------------------------
// vsu_pkg
// Shared widths, codes, beat sideband and helpers for the steering core.
// ----------------------------------------------------------------------------
`default_nettype none

package vsu_pkg;

    // Number format
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int CFG_W     = COORD_W - 1;
    localparam int MAG_W     = COORD_W;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int ROOT_W    = COORD_W;
    localparam int QUOT_W    = COORD_W - 1;
    localparam int DIVD_W    = 2 * COORD_W;
    localparam int PROD_W    = MAG_W + QUOT_W;
    localparam int SUM_W     = COORD_W + 3;

    // Pipeline depths of the iterative units
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = QUOT_W;

    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SEEK   = 3'd0;
    localparam logic [OP_W-1:0] OP_FLEE   = 3'd1;
    localparam logic [OP_W-1:0] OP_ARRIVE = 3'd2;
    localparam logic [OP_W-1:0] OP_PURSUE = 3'd3;
    localparam logic [OP_W-1:0] OP_EVADE  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_NORMAL = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOWING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP      = 2'd2;

    // Register reset values (1.0, 10.0, 1.0)
    localparam logic [CFG_W-1:0] MAX_SPEED_RST = CFG_W'(65536);
    localparam logic [CFG_W-1:0] SLOWING_RST   = CFG_W'(655360);
    localparam logic [CFG_W-1:0] STOP_RST      = CFG_W'(65536);

    // Coordinate limits at the widened sum width
    localparam logic signed [SUM_W-1:0] S_HI =
        {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] S_LO =
        {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [MAG_W-1:0]          mag_t;

    // Sideband that travels with every beat through the pipeline
    typedef struct packed {
        logic               valid;
        logic [OP_W-1:0]    op;
        coord_t [2:0]       off;
        coord_t [2:0]       vel;
        coord_t [2:0]       tv;
        mag_t   [2:0]       m;
        logic [ROOT_W-1:0]  len;
        logic [2:0]         neg;
        logic               ovf;
        logic               flag;
        logic               zero;
        logic               use_slow;
    } side_t;

    typedef struct packed {
        coord_t [2:0]          steer;
        logic [STATUS_W-1:0]   status;
    } result_t;

    // Magnitude of a coordinate; the most negative value maps to 2^(W-1)
    function automatic mag_t mag_of(input coord_t v);
        return v[COORD_W-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

    function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] s);
        coord_t r;
        if (s > S_HI) begin
            r = S_HI[COORD_W-1:0];
        end else if (s < S_LO) begin
            r = S_LO[COORD_W-1:0];
        end else begin
            r = s[COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic is_sat(input logic signed [SUM_W-1:0] s);
        return (s > S_HI) || (s < S_LO);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vector_steering_unit.sv =====
// ----------------------------------------------------------------------------
// vector_steering_unit
// Steering velocity for one agent per beat: seek, flee, arrive, pursue, evade.
// ----------------------------------------------------------------------------
// Takes one beat per clock while s_ready is high and returns one result beat
// per input beat, in order. The pipe is built from two 32-stage square root
// pipes (distance before and after target prediction) and three 31-stage
// restoring dividers in series (prediction time, arrive speed, per-axis
// scaling), plus fourteen arithmetic stages and the output register. The
// whole pipe advances together; an output register and a one-beat skid stage
// keep s_ready high while one result waits, and s_ready drops only once both
// hold a beat. All values are signed Q16.16; results saturate and report
// status 2, zero distance, a stop inside the arrive radius or an unknown
// operation code gives a zero vector with status 1. Registers may be written
// any time the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_steering_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vsu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vsu_pkg::COORD_W-1:0]         cfg_data,
    // input beats
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [vsu_pkg::OP_W-1:0]            s_op,
    input  logic signed [vsu_pkg::COORD_W-1:0]  s_offset_x,
    input  logic signed [vsu_pkg::COORD_W-1:0]  s_offset_y,
    input  logic signed [vsu_pkg::COORD_W-1:0]  s_offset_z,
    input  logic signed [vsu_pkg::COORD_W-1:0]  s_vel_x,
    input  logic signed [vsu_pkg::COORD_W-1:0]  s_vel_y,
    input  logic signed [vsu_pkg::COORD_W-1:0]  s_vel_z,
    input  logic signed [vsu_pkg::COORD_W-1:0]  s_target_vel_x,
    input  logic signed [vsu_pkg::COORD_W-1:0]  s_target_vel_y,
    input  logic signed [vsu_pkg::COORD_W-1:0]  s_target_vel_z,
    // result beats
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [vsu_pkg::COORD_W-1:0]  m_steer_x,
    output logic signed [vsu_pkg::COORD_W-1:0]  m_steer_y,
    output logic signed [vsu_pkg::COORD_W-1:0]  m_steer_z,
    output logic [vsu_pkg::STATUS_W-1:0]        m_status
);
    import vsu_pkg::*;

`include "assert_macros.svh"

    localparam logic [PROD_W-1:0] PRED_CAP = PROD_W'(1) << COORD_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] max_speed_reg, slowing_reg, stop_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= MAX_SPEED_RST;
            slowing_reg   <= SLOWING_RST;
            stop_reg      <= STOP_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_SPEED: max_speed_reg <= cfg_data[CFG_W-1:0];
                CFG_SLOWING:   slowing_reg   <= cfg_data[CFG_W-1:0];
                CFG_STOP:      stop_reg      <= cfg_data[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: whole pipe moves unless the skid stage is full
    // ------------------------------------------------------------------
    logic    en;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // Stage sidebands and data
    // ------------------------------------------------------------------
    side_t p0_side_next, p0_side_reg, p1_side_reg, p2_side_reg;
    side_t p3_side_next, p3_side_reg, p4_side_reg, p5_side_reg;
    side_t p6_side_next, p6_side_reg, p7_side_next, p7_side_reg;
    side_t p8_side_reg, p9_side_reg;
    side_t p10_side_next, p10_side_reg, p11_side_reg, p12_side_reg, p13_side_reg;
    side_t sa_side, sb_side, sc_side, sd_side;
    side_t se_side [3];

    logic [SQ_W-1:0]    p1_sq_reg [3];
    logic [SQ_W-1:0]    p2_sum_reg;
    logic [ROOT_W-1:0]  dist1;
    logic [DIVD_W-1:0]  p3_dvd_reg;
    logic [COORD_W-1:0] p3_dvs_reg;
    logic               p3_ovf;
    logic [QUOT_W-1:0]  quot1;
    logic [QUOT_W-1:0]  p4_frames_reg;
    logic [PROD_W-1:0]  p5_prod_reg [3];
    logic [PROD_W-1:0]  p6_q [3];
    logic [COORD_W:0]   p6_qc [3];
    logic signed [SUM_W-1:0] p6_pv [3];
    logic signed [SUM_W-1:0] p6_sum [3];
    logic [SQ_W-1:0]    p8_sq_reg [3];
    logic [SQ_W-1:0]    p9_sum_reg;
    logic [ROOT_W-1:0]  dist2;
    logic [ROOT_W-1:0]  p10_diff;
    logic [CFG_W-1:0]   p10_diff_reg, p10_den_reg;
    logic [2*CFG_W-1:0] p11_prod_reg;
    logic [QUOT_W-1:0]  quot2;
    logic [CFG_W-1:0]   p12_speed_reg;
    logic [PROD_W-1:0]  p13_prod_reg [3];
    logic [QUOT_W-1:0]  quot3 [3];

    // P0: capture the input beat
    always_comb begin
        p0_side_next        = '0;
        p0_side_next.valid  = s_valid;
        p0_side_next.op     = s_op;
        p0_side_next.off[0] = s_offset_x;
        p0_side_next.off[1] = s_offset_y;
        p0_side_next.off[2] = s_offset_z;
        p0_side_next.vel[0] = s_vel_x;
        p0_side_next.vel[1] = s_vel_y;
        p0_side_next.vel[2] = s_vel_z;
        p0_side_next.tv[0]  = s_target_vel_x;
        p0_side_next.tv[1]  = s_target_vel_y;
        p0_side_next.tv[2]  = s_target_vel_z;
    end

    // P3: prediction time setup; saturate when d / max_speed overflows
    always_comb begin
        p3_ovf = (max_speed_reg == '0) ||
                 ((DIVD_W'(dist1) << FRAC_BITS) >=
                  (DIVD_W'(max_speed_reg) << (COORD_W - 1)));
        p3_side_next     = sa_side;
        p3_side_next.ovf = p3_ovf;
    end

    // P6: predicted offset for pursue and evade
    always_comb begin
        p6_side_next      = p5_side_reg;
        p6_side_next.flag = 1'b0;
        for (int i = 0; i < 3; i++) begin
            p6_q[i]  = p5_prod_reg[i] >> FRAC_BITS;
            p6_qc[i] = (p6_q[i] > PRED_CAP) ? PRED_CAP[COORD_W:0] : p6_q[i][COORD_W:0];
            p6_pv[i] = $signed({{(SUM_W-COORD_W-1){1'b0}}, p6_qc[i]});
            if (p5_side_reg.tv[i][COORD_W-1]) begin
                p6_pv[i] = -p6_pv[i];
            end
            p6_sum[i] = SUM_W'($signed(p5_side_reg.off[i])) + p6_pv[i];
        end
        if (p5_side_reg.op == OP_PURSUE || p5_side_reg.op == OP_EVADE) begin
            p6_side_next.flag = p5_side_reg.ovf;
            for (int i = 0; i < 3; i++) begin
                p6_side_next.off[i] = sat_coord(p6_sum[i]);
                if (is_sat(p6_sum[i])) begin
                    p6_side_next.flag = 1'b1;
                end
            end
        end
    end

    // P7: direction flip for flee and evade, magnitudes and signs
    always_comb begin
        p7_side_next = p6_side_reg;
        for (int i = 0; i < 3; i++) begin
            p7_side_next.m[i] = mag_of(p6_side_reg.off[i]);
            if (p6_side_reg.op == OP_FLEE || p6_side_reg.op == OP_EVADE) begin
                p7_side_next.neg[i] = !p6_side_reg.off[i][COORD_W-1] &&
                                      (p6_side_reg.off[i] != '0);
            end else begin
                p7_side_next.neg[i] = p6_side_reg.off[i][COORD_W-1];
            end
        end
    end

    // P10: zero and arrive radius checks
    always_comb begin
        p10_diff                = dist2 - ROOT_W'(stop_reg);
        p10_side_next           = sc_side;
        p10_side_next.len       = dist2;
        p10_side_next.zero      = (dist2 == '0) ||
                                  ((sc_side.op == OP_ARRIVE) && (dist2 < ROOT_W'(stop_reg)));
        p10_side_next.use_slow  = (sc_side.op == OP_ARRIVE) &&
                                  (dist2 < ROOT_W'(slowing_reg));
    end

    // Sideband registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_side_reg.valid  <= 1'b0;
            p1_side_reg.valid  <= 1'b0;
            p2_side_reg.valid  <= 1'b0;
            p3_side_reg.valid  <= 1'b0;
            p4_side_reg.valid  <= 1'b0;
            p5_side_reg.valid  <= 1'b0;
            p6_side_reg.valid  <= 1'b0;
            p7_side_reg.valid  <= 1'b0;
            p8_side_reg.valid  <= 1'b0;
            p9_side_reg.valid  <= 1'b0;
            p10_side_reg.valid <= 1'b0;
            p11_side_reg.valid <= 1'b0;
            p12_side_reg.valid <= 1'b0;
            p13_side_reg.valid <= 1'b0;
        end else if (en) begin
            p0_side_reg  <= p0_side_next;
            p1_side_reg  <= p0_side_reg;
            p2_side_reg  <= p1_side_reg;
            p3_side_reg  <= p3_side_next;
            p4_side_reg  <= sb_side;
            p5_side_reg  <= p4_side_reg;
            p6_side_reg  <= p6_side_next;
            p7_side_reg  <= p7_side_next;
            p8_side_reg  <= p7_side_reg;
            p9_side_reg  <= p8_side_reg;
            p10_side_reg <= p10_side_next;
            p11_side_reg <= p10_side_reg;
            p12_side_reg <= sd_side;
            p13_side_reg <= p12_side_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p1_sq_reg[i]    <= mag_of(p0_side_reg.off[i]) * mag_of(p0_side_reg.off[i]);
                p5_prod_reg[i]  <= mag_of(p4_side_reg.tv[i]) * p4_frames_reg;
                p8_sq_reg[i]    <= p7_side_reg.m[i] * p7_side_reg.m[i];
                p13_prod_reg[i] <= p12_side_reg.m[i] * p12_speed_reg;
            end
            p2_sum_reg    <= p1_sq_reg[0] + p1_sq_reg[1] + p1_sq_reg[2];
            p3_dvd_reg    <= DIVD_W'(dist1) << FRAC_BITS;
            p3_dvs_reg    <= COORD_W'(max_speed_reg);
            p4_frames_reg <= sb_side.ovf ? {QUOT_W{1'b1}} : quot1;
            p9_sum_reg    <= p8_sq_reg[0] + p8_sq_reg[1] + p8_sq_reg[2];
            p10_diff_reg  <= p10_diff[CFG_W-1:0];
            p10_den_reg   <= slowing_reg - stop_reg;
            p11_prod_reg  <= max_speed_reg * p10_diff_reg;
            p12_speed_reg <= sd_side.use_slow ? quot2 : max_speed_reg;
        end
    end

    // Distance before prediction
    vsu_isqrt u_sqrt_pred (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .rad_i   (p2_sum_reg),
        .side_i  (p2_side_reg),
        .root_o  (dist1),
        .side_o  (sa_side)
    );

    // Prediction time d * 2^FRAC_BITS / max_speed
    vsu_udiv u_div_pred (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .dividend_i (p3_dvd_reg),
        .divisor_i  (p3_dvs_reg),
        .side_i     (p3_side_reg),
        .quot_o     (quot1),
        .side_o     (sb_side)
    );

    // Distance of the steering offset
    vsu_isqrt u_sqrt_len (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .rad_i   (p9_sum_reg),
        .side_i  (p9_side_reg),
        .root_o  (dist2),
        .side_o  (sc_side)
    );

    // Arrive speed within the slowing band
    vsu_udiv u_div_arrive (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .dividend_i (DIVD_W'(p11_prod_reg)),
        .divisor_i  (COORD_W'(p10_den_reg)),
        .side_i     (p11_side_reg),
        .quot_o     (quot2),
        .side_o     (sd_side)
    );

    // Per-axis scaling m * speed / len
    for (genvar i = 0; i < 3; i++) begin : g_axis
        vsu_udiv u_div_axis (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .dividend_i (DIVD_W'(p13_prod_reg[i])),
            .divisor_i  (p13_side_reg.len),
            .side_i     (p13_side_reg),
            .quot_o     (quot3[i]),
            .side_o     (se_side[i])
        );
    end

    // ------------------------------------------------------------------
    // Final result: desired minus current velocity, saturated
    // ------------------------------------------------------------------
    result_t                 res;
    logic                    res_sat;
    logic signed [SUM_W-1:0] res_d [3];
    logic signed [SUM_W-1:0] res_s [3];

    always_comb begin
        res_sat = se_side[0].flag;
        for (int i = 0; i < 3; i++) begin
            res_d[i] = $signed({{(SUM_W-QUOT_W){1'b0}}, quot3[i]});
            if (se_side[0].neg[i]) begin
                res_d[i] = -res_d[i];
            end
            res_s[i]        = res_d[i] - SUM_W'($signed(se_side[0].vel[i]));
            res.steer[i]    = sat_coord(res_s[i]);
            if (is_sat(res_s[i])) begin
                res_sat = 1'b1;
            end
        end
        res.status = res_sat ? ST_SAT : ST_NORMAL;
        if ((se_side[0].op > OP_EVADE) || se_side[0].zero) begin
            res.steer  = '0;
            res.status = ST_ZERO;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid stage
    // ------------------------------------------------------------------
    logic pop, push;

    assign pop  = out_valid_reg && m_ready;
    assign push = en && se_side[0].valid;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_steer_x = out_data_reg.steer[0];
    assign m_steer_y = out_data_reg.steer[1];
    assign m_steer_z = out_data_reg.steer[2];
    assign m_status  = out_data_reg.status;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ASSERT_NEVER(a_skid_without_out, skid_valid_reg && !out_valid_reg)
    `ASSERT_IMPLIES(a_zero_status_zero_vec, out_valid_reg && (out_data_reg.status == ST_ZERO), out_data_reg.steer == '0)
    `ASSERT_NEXT(a_full_skid_stalls, skid_valid_reg && !m_ready, skid_valid_reg && !s_ready)

endmodule

`default_nettype wire

// ===== rtl/core/vsu_isqrt.sv =====
// ----------------------------------------------------------------------------
// vsu_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module vsu_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [vsu_pkg::SQ_W-1:0]    rad_i,
    input  vsu_pkg::side_t              side_i,
    output logic [vsu_pkg::ROOT_W-1:0]  root_o,
    output vsu_pkg::side_t              side_o
);
    import vsu_pkg::*;

    logic [SQ_W-1:0] rem_reg  [SQRT_STAGES];
    logic [SQ_W-1:0] root_reg [SQRT_STAGES];
    side_t           side_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);

        logic [SQ_W-1:0] rem_in, root_in, trial, rem_next, root_next;
        side_t           side_in;

        if (k == 0) begin : g_first
            assign rem_in  = rad_i;
            assign root_in = '0;
            assign side_in = side_i;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // one trial subtract per stage
        always_comb begin
            trial = root_in + BIT;
            if (rem_in >= trial) begin
                rem_next  = rem_in - trial;
                root_next = (root_in >> 1) + BIT;
            end else begin
                rem_next  = rem_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[k].valid <= 1'b0;
            end else if (en) begin
                side_reg[k] <= side_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root_o = root_reg[SQRT_STAGES-1][ROOT_W-1:0];
    assign side_o = side_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/vsu_udiv.sv =====
// ----------------------------------------------------------------------------
// vsu_udiv
// Pipelined restoring divider, one quotient bit per stage. The caller keeps
// the quotient below 2^QUOT_W.
// ----------------------------------------------------------------------------
`default_nettype none

module vsu_udiv (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [vsu_pkg::DIVD_W-1:0]   dividend_i,
    input  logic [vsu_pkg::COORD_W-1:0]  divisor_i,
    input  vsu_pkg::side_t               side_i,
    output logic [vsu_pkg::QUOT_W-1:0]   quot_o,
    output vsu_pkg::side_t               side_o
);
    import vsu_pkg::*;

    logic [DIVD_W-1:0]  rem_reg  [DIV_STAGES];
    logic [COORD_W-1:0] dvs_reg  [DIV_STAGES];
    logic [QUOT_W-1:0]  quot_reg [DIV_STAGES];
    side_t              side_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int SH = QUOT_W - 1 - k;

        logic [DIVD_W-1:0]  rem_in, trial, rem_next;
        logic [COORD_W-1:0] dvs_in;
        logic [QUOT_W-1:0]  quot_in, quot_next;
        side_t              side_in;

        if (k == 0) begin : g_first
            assign rem_in  = dividend_i;
            assign dvs_in  = divisor_i;
            assign quot_in = '0;
            assign side_in = side_i;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign dvs_in  = dvs_reg[k-1];
            assign quot_in = quot_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // compare against the shifted divisor, subtract on success
        always_comb begin
            trial = DIVD_W'(dvs_in) << SH;
            if (rem_in >= trial) begin
                rem_next  = rem_in - trial;
                quot_next = quot_in | (QUOT_W'(1) << SH);
            end else begin
                rem_next  = rem_in;
                quot_next = quot_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[k].valid <= 1'b0;
            end else if (en) begin
                side_reg[k] <= side_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                dvs_reg[k]  <= dvs_in;
                quot_reg[k] <= quot_next;
            end
        end
    end

    assign quot_o = quot_reg[DIV_STAGES-1];
    assign side_o = side_reg[DIV_STAGES-1];

endmodule

`default_nettype wire
